### hw/rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Queue depth, index widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 2 * DATA_W;
  localparam int OCC_W   = 7;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

### hw/rtl/apq_ram.sv
// ----------------------------------------------------------------------------
// apq_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module apq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/array_priority_queue.sv
// ----------------------------------------------------------------------------
// array_priority_queue: bounded priority queue with linear search
// Entries kept in insertion order in one RAM; a sequencer scans and shifts.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per transfer. in_tuser carries the
//   operation (enqueue, dequeue, peek), in_tdata the value and priority
//   used by enqueue. Result channel (out_*): one response per request with
//   the status in out_tuser and top value, top priority and occupancy in
//   out_tdata.
//   Timing: the block takes one request at a time and is not ready while
//   it works on it. Enqueue and any request on an empty queue go straight
//   from idle to the done state. Peek scans all N entries, N being the
//   occupancy: the search reads one entry per cycle through the RAM read
//   port. Dequeue adds the shift of the M entries behind the top one, one
//   per cycle, with nothing to shift when the top is last.
//   Reset clears the occupancy and the handshake state; RAM contents are
//   not cleared and only slots below the occupancy are ever read.
//   Receiver stall: a result waits in the output register. The block
//   accepts the next request meanwhile and holds that one's result until
//   the register frees up.
// ----------------------------------------------------------------------------
module array_priority_queue
  import apq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] item_value, [63:32] item_priority
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] top_value, [63:32] top_priority,
                                  // [70:64] occupancy, [71] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;       // next RAM address to read
  logic              pend_r, pend_nxt;     // read data valid this cycle
  logic [ADDR_W-1:0] pend_idx_r, pend_idx_nxt;

  logic [ADDR_W-1:0]       best_idx_r, best_idx_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic signed [DATA_W-1:0] best_pri_r, best_pri_nxt;

  status_t             res_status_r, res_status_nxt;
  logic [DATA_W-1:0]   res_val_r, res_val_nxt;
  logic [DATA_W-1:0]   res_pri_r, res_pri_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_val_r, out_val_nxt;
  logic [DATA_W-1:0]   out_pri_r, out_pri_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] rd_pri;
  logic                     rd_better;
  logic                     in_fire;

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val = ram_rdata[DATA_W-1:0];
  assign rd_pri = ram_rdata[ENTRY_W-1:DATA_W];

  // Compare: higher priority wins, then higher value; earlier on full tie.
  assign rd_better = (rd_pri > best_pri_r) || ((rd_pri == best_pri_r) && (rd_val > best_val_r));

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_val_r   <= best_val_nxt;
    best_pri_r   <= best_pri_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_pri_r    <= res_pri_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_pri_r    <= out_pri_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    best_idx_nxt   = best_idx_r;
    best_val_nxt   = best_val_r;
    best_pri_nxt   = best_pri_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_pri_nxt    = res_pri_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_pri_nxt    = out_pri_r;
    out_occ_nxt    = out_occ_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[ADDR_W-1:0];
    ram_wdata      = {in_tdata[63:32], in_tdata[31:0]};
    ram_raddr      = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = op_t'(in_tuser);
          res_status_nxt = ST_OK;
          res_val_nxt    = '0;
          res_pri_nxt    = '0;
          idx_nxt        = '0;
          state_nxt      = S_DONE;
          unique case (in_tuser)
            OP_ENQUEUE: begin
              if (count_r >= CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[ADDR_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          // entry 0 seeds the search
          if ((pend_idx_r == '0) || rd_better) begin
            best_idx_nxt = pend_idx_r;
            best_val_nxt = rd_val;
            best_pri_nxt = rd_pri;
          end
        end else if (idx_r == count_r) begin
          res_val_nxt = best_val_r;
          res_pri_nxt = best_pri_r;
          if (op_r == OP_DEQUEUE) begin
            idx_nxt   = CNT_W'(best_idx_r) + CNT_W'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        if (idx_r < count_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[ADDR_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end else if (idx_r >= count_r) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          out_pri_nxt    = res_pri_r;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_occ_r, out_pri_r, out_val_r};

endmodule

### hw/rtl/apq_chk.sv
// ----------------------------------------------------------------------------
// apq_chk: port-level checker for the array priority queue
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module apq_chk
  import apq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  logic [OCC_W-1:0] occ;
  assign occ = out_tdata[70:64];

  // stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("response changed while stalled");

  // one request in flight: ready drops right after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> occ == OCC_W'(DEPTH))
    else $error("full status with room left");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |-> (occ == '0) && (out_tdata[63:0] == '0))
    else $error("empty status with entries or data");

endmodule

bind array_priority_queue apq_chk u_apq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### test/array_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_priority_queue_tb: self-checking bench for the array priority queue
// Drives enqueue, dequeue, peek and unused-op requests with random gaps and
// output stalls. A behavioral queue predicts every response, which is checked
// field by field. Covers empty and full queues, priority and value ties,
// extreme values, a long output stall and a full pause of the sender.
// ----------------------------------------------------------------------------
module array_priority_queue_tb;
  import apq_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 500_000;
  localparam logic [31:0] INT_MIN    = 32'h8000_0000;
  localparam logic [31:0] INT_MAX    = 32'h7fff_ffff;

  typedef struct {
    status_t            status;
    logic signed [31:0] top_value;
    logic signed [31:0] top_priority;
    logic [6:0]         occupancy;
  } apq_response_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [31:0] item_value, [63:32] item_priority
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // [31:0] top_value, [63:32] top_priority, [70:64] occupancy
  logic [1:0]  out_tuser;  // [1:0] status

  // behavioral copy of the queue, updated at each accepted request
  logic signed [31:0] slot_value [DEPTH];
  logic signed [31:0] slot_priority [DEPTH];
  int                 held;

  apq_response_t pending_responses [$];

  int  errors;
  int  cycles;
  int  requests_by_op [4];
  int  responses_seen;
  int  full_seen;
  int  empty_seen;
  int  peak_held;
  bit  tx_idle;
  bit  rx_idle;
  int  rx_hold_cycles;

  array_priority_queue u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** array_priority_queue: FAILED **");
      $finish;
    end
  end

  // Highest priority wins, then higher value, then the earliest slot.
  function automatic apq_response_t apply_request(logic [1:0] op, logic signed [31:0] val,
                                                  logic signed [31:0] pri);
    apq_response_t r;
    int            best;
    r.status       = ST_OK;
    r.top_value    = '0;
    r.top_priority = '0;
    case (op)
      OP_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_value[held]    = val;
          slot_priority[held] = pri;
          held++;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held; i++) begin
            if (slot_priority[i] > slot_priority[best] ||
                (slot_priority[i] == slot_priority[best] && slot_value[i] > slot_value[best]))
              best = i;
          end
          r.top_value    = slot_value[best];
          r.top_priority = slot_priority[best];
          if (op == OP_DEQUEUE) begin
            for (int i = best; i + 1 < held; i++) begin
              slot_value[i]    = slot_value[i + 1];
              slot_priority[i] = slot_priority[i + 1];
            end
            held--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = held[6:0];
    return r;
  endfunction

  // Mix of full-range words, small clustered values and extremes, so ties occur.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 3))
      0: w = $urandom;
      1: w = 32'($urandom_range(0, 8)) - 32'd4;
      2: begin
        case ($urandom_range(0, 3))
          0:       w = INT_MIN;
          1:       w = INT_MAX;
          2:       w = 32'd0;
          default: w = 32'hffff_ffff;
        endcase
      end
      default: w = 32'($urandom_range(0, 3)) * 32'd1000 - 32'd1500;
    endcase
    return w;
  endfunction

  function automatic logic [1:0] pick_op(int enqueue_pct);
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < enqueue_pct)
      op = OP_ENQUEUE;
    else if (r < 98)
      op = $urandom_range(0, 1) ? OP_DEQUEUE : OP_PEEK;
    else
      op = OP_UNUSED;
    return op;
  endfunction

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(input logic [1:0] op, input logic [31:0] val,
                              input logic [31:0] pri);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pri, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_responses.push_back(apply_request(op, val, pri));
    requests_by_op[op]++;
    if (held > peak_held) peak_held = held;
  endtask

  task automatic send_random(int enqueue_pct);
    send_request(pick_op(enqueue_pct), rand_word(), rand_word());
  endtask

  task automatic wait_for_responses();
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  initial begin : rx_side
    int stall;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && rx_hold_cycles == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_responses
    apq_response_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      responses_seen++;
      if (out_tuser == ST_FULL) full_seen++;
      if (out_tuser == ST_EMPTY) empty_seen++;
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding: status %0d", out_tuser);
        errors++;
      end else begin
        exp = pending_responses.pop_front();
        if (out_tuser != exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] != exp.top_value) begin
          $error("top_value: expected %0d, got %0d", exp.top_value, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[63:32] != exp.top_priority) begin
          $error("top_priority: expected %0d, got %0d", exp.top_priority,
                 $signed(out_tdata[63:32]));
          errors++;
        end
        if (out_tdata[70:64] != exp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp.occupancy, out_tdata[70:64]);
          errors++;
        end
        if (out_tdata[71] != 1'b0) begin
          $error("tdata pad bit: expected 0, got %0b", out_tdata[71]);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(OP_PEEK, 32'h1234_5678, 32'h9abc_def0);
    send_request(OP_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_extremes_and_ties();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // lone entry at the most negative priority must still be found
    send_request(OP_ENQUEUE, INT_MIN, INT_MIN);
    send_request(OP_PEEK, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_ENQUEUE, 32'd5, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 32'd7, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 32'd7, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 32'hffff_fffd, INT_MAX);
    send_request(OP_ENQUEUE, INT_MAX, INT_MAX);
    send_request(OP_ENQUEUE, INT_MIN, INT_MIN);
    send_request(OP_PEEK, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_UNUSED, INT_MAX, INT_MIN);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
    send_request(OP_PEEK, 32'd0, 32'd0);
    send_request(OP_ENQUEUE, $urandom, $urandom);
    send_request(OP_DEQUEUE, 32'd0, 32'd0);
  endtask

  task automatic test_fill_until_full();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (held < DEPTH) send_random(85);
    repeat (6) send_request(OP_ENQUEUE, rand_word(), rand_word());
    send_request(OP_PEEK, 32'd0, 32'd0);
  endtask

  task automatic test_drain_until_empty();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    while (held > 0) send_random(5);
    send_request(OP_DEQUEUE, rand_word(), rand_word());
    send_request(OP_PEEK, rand_word(), rand_word());
  endtask

  task automatic test_mixed_traffic();
    for (int stretch = 0; stretch < 4; stretch++) begin
      tx_idle = (stretch == 0 || stretch == 2);
      rx_idle = (stretch == 0 || stretch == 3);
      repeat (30) send_random(55);
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 300;
    repeat (30) send_random(60);
  endtask

  task automatic test_pause_and_resume();
    in_tvalid <= 1'b0;
    wait_for_responses();
    @(posedge clk);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (50) send_random(50);
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= OP_ENQUEUE;
    errors         = 0;
    cycles         = 0;
    held           = 0;
    responses_seen = 0;
    full_seen      = 0;
    empty_seen     = 0;
    peak_held      = 0;
    rx_hold_cycles = 0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    foreach (requests_by_op[i]) requests_by_op[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_extremes_and_ties();
    test_fill_until_full();
    test_drain_until_empty();
    test_mixed_traffic();
    test_output_backpressure();
    test_pause_and_resume();

    in_tvalid <= 1'b0;
    wait_for_responses();
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d unused op",
             requests_by_op[0] + requests_by_op[1] + requests_by_op[2] + requests_by_op[3],
             requests_by_op[0], requests_by_op[1], requests_by_op[2], requests_by_op[3]);
    $display("%0d responses, %0d full drops, %0d empty, peak occupancy %0d",
             responses_seen, full_seen, empty_seen, peak_held);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("** array_priority_queue: PASSED **");
    end else begin
      $display("** array_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
